// ===== design/bec_pkg.sv =====
// types and constants for the button event classifier
// used by the config block, the classifier core and the top level
package bec_pkg;

    localparam int unsigned CfgAddrWidth = 5;
    localparam int unsigned CfgDataWidth = 32;

    // register indexes, byte address is four times the index
    localparam logic [2:0] REG_INVERT_LEVEL       = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE_MS        = 3'd1;
    localparam logic [2:0] REG_TAP_MS             = 3'd2;
    localparam logic [2:0] REG_DOUBLE_TAP_MS      = 3'd3;
    localparam logic [2:0] REG_LONG_PRESS_MS      = 3'd4;
    localparam logic [2:0] REG_REPEAT_DELAY_MS    = 3'd5;
    localparam logic [2:0] REG_REPEAT_INTERVAL_MS = 3'd6;

    typedef enum logic [3:0] {
        EV_NONE          = 4'd0,
        EV_TOUCH         = 4'd1,
        EV_RELEASE       = 4'd2,
        EV_TAP           = 4'd3,
        EV_DOUBLE_TAP    = 4'd4,
        EV_PRESSED       = 4'd5,
        EV_PRESSING      = 4'd6,
        EV_LONG_PRESSED  = 4'd7,
        EV_LONG_PRESSING = 4'd8
    } event_t;

    typedef struct packed {
        logic        invert_level;
        logic [15:0] debounce_ms;
        logic [15:0] tap_ms;
        logic [15:0] double_tap_ms;
        logic [15:0] long_press_ms;
        logic [15:0] repeat_delay_ms;
        logic [15:0] repeat_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        pin_level;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  event_code;
        logic [15:0] event_duration;
        logic        is_pressed;
        logic        just_changed;
    } out_item_t;

endpackage

// ===== design/bec_cfg.sv =====
// apb-style configuration registers of the button event classifier
// depends on bec_pkg for the register indexes and the cfg_t struct
module bec_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bec_pkg::CfgAddrWidth-1:0]  paddr,
    input  logic [bec_pkg::CfgDataWidth-1:0]  pwdata,
    output logic [bec_pkg::CfgDataWidth-1:0]  prdata,
    output logic                              pready,
    output bec_pkg::cfg_t                     cfg
);
    import bec_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[CfgAddrWidth-1:2];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_INVERT_LEVEL:       cfg_next.invert_level       = pwdata[0];
                REG_DEBOUNCE_MS:        cfg_next.debounce_ms        = pwdata[15:0];
                REG_TAP_MS:             cfg_next.tap_ms             = pwdata[15:0];
                REG_DOUBLE_TAP_MS:      cfg_next.double_tap_ms      = pwdata[15:0];
                REG_LONG_PRESS_MS:      cfg_next.long_press_ms      = pwdata[15:0];
                REG_REPEAT_DELAY_MS:    cfg_next.repeat_delay_ms    = pwdata[15:0];
                REG_REPEAT_INTERVAL_MS: cfg_next.repeat_interval_ms = pwdata[15:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_INVERT_LEVEL:       prdata = {31'd0, cfg_reg.invert_level};
            REG_DEBOUNCE_MS:        prdata = {16'd0, cfg_reg.debounce_ms};
            REG_TAP_MS:             prdata = {16'd0, cfg_reg.tap_ms};
            REG_DOUBLE_TAP_MS:      prdata = {16'd0, cfg_reg.double_tap_ms};
            REG_LONG_PRESS_MS:      prdata = {16'd0, cfg_reg.long_press_ms};
            REG_REPEAT_DELAY_MS:    prdata = {16'd0, cfg_reg.repeat_delay_ms};
            REG_REPEAT_INTERVAL_MS: prdata = {16'd0, cfg_reg.repeat_interval_ms};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invert_level       <= 1'b0;
            cfg_reg.debounce_ms        <= 16'd10;
            cfg_reg.tap_ms             <= 16'd150;
            cfg_reg.double_tap_ms      <= 16'd300;
            cfg_reg.long_press_ms      <= 16'd0;
            cfg_reg.repeat_delay_ms    <= 16'd0;
            cfg_reg.repeat_interval_ms <= 16'd200;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/bec_core.sv =====
// classifier core: button state registers and the per-poll event logic
// depends on bec_pkg for cfg_t, the item structs and the event codes
module bec_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  bec_pkg::in_item_t  item,
    input  bec_pkg::cfg_t      cfg,
    output bec_pkg::out_item_t result
);
    import bec_pkg::*;

    logic        pressed_reg,        pressed_next;
    logic        changed_reg,        changed_next;
    logic        tap_waiting_reg,    tap_waiting_next;
    logic        press_reported_reg, press_reported_next;
    logic        long_reported_reg,  long_reported_next;
    logic [31:0] poll_time_reg,      poll_time_next;
    logic [31:0] change_time_reg,    change_time_next;
    logic [31:0] press_start_reg,    press_start_next;
    logic [31:0] repeat_time_reg,    repeat_time_next;

    logic [31:0] held_dur;
    logic [31:0] since_repeat;
    logic [31:0] since_change;
    logic [31:0] new_dur;
    logic        level;
    logic        early;
    event_t      ev;
    logic [31:0] dur;

    assign held_dur     = poll_time_reg - press_start_reg;
    assign since_repeat = poll_time_reg - repeat_time_reg;
    assign level        = item.pin_level ^ cfg.invert_level;
    assign new_dur      = item.now_ms - press_start_reg;
    // change time after the clear of the changed flag
    assign change_time_next = changed_reg ? poll_time_reg : change_time_reg;
    assign since_change = item.now_ms - change_time_next;

    always_comb
    begin
        pressed_next        = pressed_reg;
        changed_next        = 1'b0;
        tap_waiting_next    = tap_waiting_reg;
        press_reported_next = press_reported_reg;
        long_reported_next  = long_reported_reg;
        poll_time_next      = poll_time_reg;
        press_start_next    = press_start_reg;
        repeat_time_next    = repeat_time_reg;
        ev                  = EV_NONE;
        dur                 = held_dur;

        if (changed_reg)
        begin
            // release events right after a debounced release
            if (!pressed_reg)
            begin
                if (held_dur <= {16'd0, cfg.tap_ms})
                begin
                    if (tap_waiting_reg)
                    begin
                        tap_waiting_next    = 1'b0;
                        press_reported_next = 1'b0;
                        long_reported_next  = 1'b0;
                        ev                  = EV_DOUBLE_TAP;
                    end
                    else
                    begin
                        tap_waiting_next = 1'b1;
                    end
                end
                else if (press_reported_reg)
                begin
                    ev = long_reported_reg ? EV_LONG_PRESSED : EV_PRESSED;
                    press_reported_next = 1'b0;
                    long_reported_next  = 1'b0;
                end
            end
        end
        else
        begin
            // timeouts, measured at the previous poll time
            if (tap_waiting_reg && held_dur >= {16'd0, cfg.double_tap_ms})
            begin
                tap_waiting_next    = 1'b0;
                press_reported_next = 1'b0;
                ev                  = EV_TAP;
            end
            else if (pressed_reg)
            begin
                if ((!press_reported_reg && held_dur > {16'd0, cfg.tap_ms}) ||
                    (cfg.repeat_delay_ms != 16'd0 &&
                     held_dur > {16'd0, cfg.repeat_delay_ms} &&
                     since_repeat > {16'd0, cfg.repeat_interval_ms}))
                begin
                    repeat_time_next    = poll_time_reg;
                    press_reported_next = 1'b1;
                    ev                  = EV_PRESSING;
                end
                else if (cfg.long_press_ms != 16'd0 && !long_reported_reg &&
                         held_dur > {16'd0, cfg.long_press_ms})
                begin
                    long_reported_next = 1'b1;
                    ev                 = EV_LONG_PRESSING;
                end
            end
        end

        early = (ev != EV_NONE);

        // no early event: take the new sample through the debounce
        if (!early)
        begin
            dur            = '0;
            poll_time_next = item.now_ms;
            if (level != pressed_reg && since_change >= {16'd0, cfg.debounce_ms})
            begin
                changed_next = 1'b1;
                pressed_next = level;
                if (level)
                begin
                    press_start_next = item.now_ms;
                    ev               = EV_TOUCH;
                end
                else
                begin
                    dur = new_dur;
                    ev  = EV_RELEASE;
                end
            end
        end
    end

    always_comb
    begin
        result.event_code     = ev;
        result.event_duration = dur[15:0];
        result.is_pressed     = pressed_next;
        result.just_changed   = changed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg        <= 1'b0;
            changed_reg        <= 1'b0;
            tap_waiting_reg    <= 1'b0;
            press_reported_reg <= 1'b0;
            long_reported_reg  <= 1'b0;
            poll_time_reg      <= '0;
            change_time_reg    <= '0;
            press_start_reg    <= '0;
            repeat_time_reg    <= '0;
        end
        else if (step)
        begin
            pressed_reg        <= pressed_next;
            changed_reg        <= changed_next;
            tap_waiting_reg    <= tap_waiting_next;
            press_reported_reg <= press_reported_next;
            long_reported_reg  <= long_reported_next;
            poll_time_reg      <= poll_time_next;
            change_time_reg    <= change_time_next;
            press_start_reg    <= press_start_next;
            repeat_time_reg    <= repeat_time_next;
        end
    end

endmodule

// ===== design/button_event_classifier_unit.sv =====
// top level of the button event classifier: input and result registers
// depends on bec_pkg, bec_cfg and bec_core
//
// usage: each transfer on the in channel is one poll of a push button, the
// millisecond time stamp now_ms and the raw pin level. every poll gives exactly
// one result on the out channel: an event code (none, touch, release, tap,
// double tap, pressed, pressing, long pressed, long pressing), the low 16 bits
// of the press duration, the debounced pressed state and a changed flag.
// a poll waits in the input register, the event logic runs between that
// register and the result register, which holds the result on the out
// channel until it is transferred. one poll per cycle is sustained while
// the receiver takes every result; the rate is set by the single pass of
// compares and 32-bit subtractions against the state registers.
// when the receiver stalls, the result register holds its item and the input
// register takes one more poll only if empty; then in_ready drops until the
// result is taken. reset clears the button state and both valid flags and loads
// the register defaults (debounce 10, tap 150, double tap 300, repeat interval
// 200, the rest 0). write the registers only while no poll is in flight.
module button_event_classifier_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bec_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bec_pkg::out_item_t                out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bec_pkg::CfgAddrWidth-1:0]  paddr,
    input  logic [bec_pkg::CfgDataWidth-1:0]  pwdata,
    output logic [bec_pkg::CfgDataWidth-1:0]  prdata,
    output logic                              pready
);
    import bec_pkg::*;

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg,  in_valid_next;
    out_item_t out_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t result;
    logic      step;

    // the held poll moves on when the result register is free or drains now
    assign step      = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready  = ~in_valid_reg | step;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_valid_next  = (in_valid & in_ready) | (in_valid_reg & ~step);
    assign out_valid_next = step | (out_valid_reg & ~out_ready);

    bec_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bec_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid & in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== test/tb_button_event_classifier_unit.sv =====
// testbench for button_event_classifier_unit: a directed table of polls, then random press
// patterns under several register settings, checked against table or behavioral predictor
// depends on bec_pkg and the design sources of the classifier
module tb_button_event_classifier_unit;
    import bec_pkg::*;

    localparam int unsigned WatchdogLimit = 3000;
    localparam int unsigned NumPhases     = 8;
    localparam int unsigned PollsPerPhase = 212;

    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  reg_idx;
        logic [15:0] reg_val;
        in_item_t    poll;
        logic        has_want;
        out_item_t   want;
    } step_row_t;

    typedef struct packed {
        logic      has_want;
        out_item_t want;
    } poll_note_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    in_item_t                in_data;
    logic                    out_valid;
    logic                    out_ready;
    out_item_t               out_data;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CfgAddrWidth-1:0] paddr;
    logic [CfgDataWidth-1:0] pwdata;
    logic [CfgDataWidth-1:0] prdata;
    logic                    pready;

    // predictor copy of the registers and the button state
    cfg_t        cfg_shadow;
    logic        btn_pressed = 1'b0;
    logic        btn_changed = 1'b0;
    logic        tap_pending = 1'b0;
    logic        press_seen  = 1'b0;
    logic        long_seen   = 1'b0;
    logic [31:0] poll_ts     = '0;
    logic [31:0] change_ts   = '0;
    logic [31:0] press_ts    = '0;
    logic [31:0] repeat_ts   = '0;

    out_item_t   expected_events[$];
    poll_note_t  poll_notes[$];
    step_row_t   plan[$];

    int unsigned err_count    = 0;
    int unsigned polls_done   = 0;
    int unsigned writes_done  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned event_tally[9];

    button_event_classifier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // one poll of the button: early release/timeout events first, then the debounced level
    function automatic out_item_t classify_poll(in_item_t p);
        out_item_t   r;
        event_t      ev;
        logic [31:0] dur;
        logic        lvl;
        lvl = p.pin_level ^ cfg_shadow.invert_level;
        ev  = EV_NONE;
        dur = '0;
        if (btn_changed)
        begin
            btn_changed = 1'b0;
            change_ts   = poll_ts;
            if (!btn_pressed)
            begin
                dur = poll_ts - press_ts;
                if (dur <= cfg_shadow.tap_ms)
                begin
                    if (tap_pending)
                    begin
                        tap_pending = 1'b0;
                        press_seen  = 1'b0;
                        long_seen   = 1'b0;
                        ev          = EV_DOUBLE_TAP;
                    end
                    else
                        tap_pending = 1'b1;
                end
                else if (press_seen)
                begin
                    ev         = long_seen ? EV_LONG_PRESSED : EV_PRESSED;
                    press_seen = 1'b0;
                    long_seen  = 1'b0;
                end
            end
        end
        else
        begin
            // timeouts look at the previous poll time
            dur = poll_ts - press_ts;
            if (tap_pending && dur >= cfg_shadow.double_tap_ms)
            begin
                tap_pending = 1'b0;
                press_seen  = 1'b0;
                ev          = EV_TAP;
            end
            else if (btn_pressed)
            begin
                if ((!press_seen && dur > cfg_shadow.tap_ms) ||
                    (cfg_shadow.repeat_delay_ms != 0 && dur > cfg_shadow.repeat_delay_ms &&
                     (poll_ts - repeat_ts) > cfg_shadow.repeat_interval_ms))
                begin
                    repeat_ts  = poll_ts;
                    press_seen = 1'b1;
                    ev         = EV_PRESSING;
                end
                else if (cfg_shadow.long_press_ms != 0 && !long_seen &&
                         dur > cfg_shadow.long_press_ms)
                begin
                    long_seen = 1'b1;
                    ev        = EV_LONG_PRESSING;
                end
            end
        end
        if (ev == EV_NONE)
        begin
            dur     = '0;
            poll_ts = p.now_ms;
            if (lvl != btn_pressed && (poll_ts - change_ts) >= cfg_shadow.debounce_ms)
            begin
                if (lvl)
                begin
                    press_ts = poll_ts;
                    ev       = EV_TOUCH;
                end
                else
                begin
                    dur = poll_ts - press_ts;
                    ev  = EV_RELEASE;
                end
                btn_pressed = lvl;
                btn_changed = 1'b1;
            end
        end
        r.event_code     = ev;
        r.event_duration = dur[15:0];
        r.is_pressed     = btn_pressed;
        r.just_changed   = btn_changed;
        return r;
    endfunction

    function automatic step_row_t row_poll(logic [31:0] t, logic lvl, logic has_want = 1'b0,
                                           event_t ev = EV_NONE, logic [15:0] d = '0,
                                           logic p = 1'b0, logic c = 1'b0);
        step_row_t r;
        r                     = '0;
        r.poll.now_ms         = t;
        r.poll.pin_level      = lvl;
        r.has_want            = has_want;
        r.want.event_code     = ev;
        r.want.event_duration = d;
        r.want.is_pressed     = p;
        r.want.just_changed   = c;
        return r;
    endfunction

    function automatic step_row_t row_cfg(logic [2:0] idx, logic [15:0] v);
        step_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = v;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned pick_hold(int unsigned thr);
        int unsigned r;
        int unsigned tap;
        tap = 32'(cfg_shadow.tap_ms);
        r   = $urandom_range(0, 9);
        if (r < 4)
            return $urandom_range(0, tap + 1);
        else if (r < 7)
            return $urandom_range(tap, 2 * tap + thr / 2 + 1);
        return $urandom_range(0, 3 * thr);
    endfunction

    function automatic cfg_t pick_setting(int unsigned k);
        cfg_t s;
        case (k)
            0: s = '0;
            1: s = '1;
            2: s = '{1'b0, 16'd10, 16'd150, 16'd300, 16'd0, 16'd0, 16'd200};
            // long pressing fires well before pressing, with fast repeat
            3: s = '{1'b1, 16'd5, 16'd200, 16'd250, 16'd60, 16'd400, 16'd30};
            default:
            begin
                s.invert_level       = 1'($urandom_range(0, 1));
                s.debounce_ms        = 16'($urandom_range(0, 40));
                s.tap_ms             = 16'($urandom_range(0, 400));
                s.double_tap_ms      = 16'($urandom_range(0, 600));
                s.long_press_ms      = ($urandom_range(0, 3) == 0) ? 16'd0 :
                                       16'($urandom_range(1, 600));
                s.repeat_delay_ms    = ($urandom_range(0, 3) == 0) ? 16'd0 :
                                       16'($urandom_range(1, 800));
                s.repeat_interval_ms = 16'($urandom_range(0, 300));
            end
        endcase
        return s;
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, what, want, got);
            err_count++;
        end
    endtask

    // apb write: setup cycle, access cycle, register taken at the following edge
    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_INVERT_LEVEL:       cfg_shadow.invert_level       = v[0];
            REG_DEBOUNCE_MS:        cfg_shadow.debounce_ms        = v;
            REG_TAP_MS:             cfg_shadow.tap_ms             = v;
            REG_DOUBLE_TAP_MS:      cfg_shadow.double_tap_ms      = v;
            REG_LONG_PRESS_MS:      cfg_shadow.long_press_ms      = v;
            REG_REPEAT_DELAY_MS:    cfg_shadow.repeat_delay_ms    = v;
            REG_REPEAT_INTERVAL_MS: cfg_shadow.repeat_interval_ms = v;
            default: ;
        endcase
        writes_done++;
        // idle before returning, so back-to-back writes start on a fresh edge
        @(posedge clk);
    endtask

    task automatic apply_setting(cfg_t s);
        write_reg(REG_INVERT_LEVEL, {15'd0, s.invert_level});
        write_reg(REG_DEBOUNCE_MS, s.debounce_ms);
        write_reg(REG_TAP_MS, s.tap_ms);
        write_reg(REG_DOUBLE_TAP_MS, s.double_tap_ms);
        write_reg(REG_LONG_PRESS_MS, s.long_press_ms);
        write_reg(REG_REPEAT_DELAY_MS, s.repeat_delay_ms);
        write_reg(REG_REPEAT_INTERVAL_MS, s.repeat_interval_ms);
    endtask

    // hold the sender until every expected result is back, then let the pipeline drain
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_events.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_poll(in_item_t p, logic has_want, out_item_t want, int unsigned gap);
        poll_note_t n;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        n.has_want = has_want;
        n.want     = want;
        poll_notes = {poll_notes, n};
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // receiver: runs of ready broken by stalls, sometimes a long stretch with no stall
    initial
    begin
        int unsigned gap;
        int unsigned run;
        out_ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            gap = idle_gap();
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        poll_note_t n;
        out_item_t  predicted;
        out_item_t  want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                n         = poll_notes.pop_front();
                predicted = classify_poll(in_data);
                event_tally[predicted.event_code]++;
                want            = n.has_want ? n.want : predicted;
                expected_events = {expected_events, want};
                polls_done++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t result transfer with nothing expected: %h", $time, out_data);
                    err_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_code", 32'(want.event_code),
                                32'(out_data.event_code));
                    check_field("event_duration", 32'(want.event_duration),
                                32'(out_data.event_duration));
                    check_field("is_pressed", 32'(want.is_pressed),
                                32'(out_data.is_pressed));
                    check_field("just_changed", 32'(want.just_changed),
                                32'(out_data.just_changed));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("%0t no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb_button_event_classifier_unit: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] clock_ms;
        logic        held_level;
        int unsigned hold_left;
        int unsigned thr;
        int unsigned stepv;
        int unsigned r;
        logic        calm;
        in_item_t    p;

        rst_n      = 1'b0;
        cfg_shadow = '{1'b0, 16'd10, 16'd150, 16'd300, 16'd0, 16'd0, 16'd200};
        in_valid  <= 1'b0;
        in_data   <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan = '{
            // reset defaults: touch, debounce reject, release, tap armed, tap times out
            row_poll(32'd100, 1'b1, 1'b1, EV_TOUCH, 16'd0, 1'b1, 1'b1),
            row_poll(32'd105, 1'b0, 1'b1, EV_NONE, 16'd0, 1'b1, 1'b0),
            row_poll(32'd180, 1'b0, 1'b1, EV_RELEASE, 16'd80, 1'b0, 1'b1),
            row_poll(32'd200, 1'b0, 1'b1, EV_NONE, 16'd0, 1'b0, 1'b0),
            row_poll(32'd600, 1'b0, 1'b1, EV_NONE, 16'd0, 1'b0, 1'b0),
            row_poll(32'd601, 1'b0, 1'b1, EV_TAP, 16'd500, 1'b0, 1'b0),
            // two short presses give a double tap
            row_poll(32'd700, 1'b1), row_poll(32'd720, 1'b0), row_poll(32'd730, 1'b0),
            row_poll(32'd760, 1'b1), row_poll(32'd780, 1'b0), row_poll(32'd790, 1'b0),
            // held past the tap limit: pressing, then pressed on release
            row_poll(32'd1000, 1'b1), row_poll(32'd1200, 1'b1), row_poll(32'd1201, 1'b1),
            row_poll(32'd1300, 1'b0), row_poll(32'd1310, 1'b0),
            row_cfg(REG_LONG_PRESS_MS, 16'd50),
            row_cfg(REG_REPEAT_DELAY_MS, 16'd100),
            row_cfg(REG_REPEAT_INTERVAL_MS, 16'd0),
            // long pressing ahead of pressing, auto-repeat, long pressed across the wrap
            row_poll(32'd2000, 1'b1), row_poll(32'd2070, 1'b1), row_poll(32'd2071, 1'b1),
            row_poll(32'd2300, 1'b1), row_poll(32'd2301, 1'b1), row_poll(32'd2302, 1'b1),
            row_poll(32'd2303, 1'b1), row_poll(32'hFFFF_FFFF, 1'b0), row_poll(32'd0, 1'b0),
            row_cfg(REG_INVERT_LEVEL, 16'd1),
            // inverted level, debounce measured across the wrap
            row_poll(32'd3, 1'b0), row_poll(32'd20, 1'b0)
        };
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_poll(plan[i].poll, plan[i].has_want, plan[i].want, idle_gap());
        end

        for (int unsigned ph = 0; ph < NumPhases; ph++)
        begin
            settle();
            apply_setting(pick_setting(ph));
            thr = 20;
            if (cfg_shadow.debounce_ms > thr)     thr = 32'(cfg_shadow.debounce_ms);
            if (cfg_shadow.tap_ms > thr)          thr = 32'(cfg_shadow.tap_ms);
            if (cfg_shadow.double_tap_ms > thr)   thr = 32'(cfg_shadow.double_tap_ms);
            if (cfg_shadow.long_press_ms > thr)   thr = 32'(cfg_shadow.long_press_ms);
            if (cfg_shadow.repeat_delay_ms > thr) thr = 32'(cfg_shadow.repeat_delay_ms);
            clock_ms   = $urandom();
            held_level = 1'($urandom_range(0, 1));
            hold_left  = pick_hold(thr);
            calm       = 1'b0;
            for (int unsigned k = 0; k < PollsPerPhase; k++)
            begin
                if (k % 100 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                // time moves in small steps against the thresholds, with rare big jumps
                r = $urandom_range(0, 19);
                if (r < 14)
                    stepv = $urandom_range(0, thr / 16 + 1);
                else if (r < 19)
                    stepv = $urandom_range(0, thr / 3 + 1);
                else
                    stepv = $urandom_range(0, 4 * thr);
                if ($urandom_range(0, 59) == 0)
                    clock_ms = $urandom();
                else
                    clock_ms += stepv;
                if (stepv >= hold_left)
                begin
                    held_level = ~held_level;
                    hold_left  = pick_hold(thr);
                end
                else
                    hold_left -= stepv;
                p.now_ms    = clock_ms;
                // single-poll bounce on the pin
                p.pin_level = held_level ^ ($urandom_range(0, 24) == 0);
                if ($urandom_range(0, 149) == 0)
                    settle();
                send_poll(p, 1'b0, '0, calm ? 0 : idle_gap());
            end
        end

        settle();
        $display("covered %0d polls, %0d register writes over %0d register settings plus directed",
                 polls_done, writes_done, NumPhases);
        $display("events: touch %0d release %0d tap %0d double %0d pressed %0d pressing %0d %s %0d %0d",
                 event_tally[EV_TOUCH], event_tally[EV_RELEASE], event_tally[EV_TAP],
                 event_tally[EV_DOUBLE_TAP], event_tally[EV_PRESSED], event_tally[EV_PRESSING],
                 "long pressed/pressing", event_tally[EV_LONG_PRESSED],
                 event_tally[EV_LONG_PRESSING]);
        if (err_count == 0)
            $display("tb_button_event_classifier_unit: done, clean");
        else
            $display("tb_button_event_classifier_unit: done, errors");
        $finish;
    end

endmodule
